// ===== src/pcx_pkg.sv =====
// Package for the cycle crossover block: payload structs, command and state types, constants.
// Used by the top level, pcx_front and pcx_back; depends on nothing.

package pcx_pkg;

	localparam int CITY_W      = 7;
	localparam int CITY_SLOTS  = 128;
	localparam int OUT_POS_W   = 7;
	localparam int CMD_POS_W   = 10;
	localparam int TL_W        = 8;
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 3;

	localparam logic [TL_W-1:0] TOUR_LENGTH_RESET = 8'd100;
	localparam logic            REG_TOUR_LENGTH   = 1'b0;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_READ = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [CITY_W-1:0] first_parent_city;
		logic [CITY_W-1:0] second_parent_city;
	} item_t;

	typedef struct packed {
		logic [CITY_W-1:0]    child_city;
		logic [OUT_POS_W-1:0] child_position;
		logic                 last;
	} result_t;

	typedef enum logic {
		CMD_LOAD,
		CMD_READ
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [CMD_POS_W-1:0] pos;
		logic [CITY_W-1:0] fc;
		logic [CITY_W-1:0] sc;
		logic              last;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_WALK_START,
		BK_WALK_SP,
		BK_WALK_MAP
	} back_state_t;

endpackage

// ===== src/permutation_cycle_crossover.sv =====
// Top level of the cycle crossover block: register port, front end, command queue, back end.
// Depends on pcx_pkg, pcx_fifo, pcx_front, pcx_back (and pcx_ram through pcx_back).

// Cycle crossover of two permutation tours. Push load transactions (mode 0) carrying one
// pair of parent cities per position until tour_length pairs are in; the block then walks
// the cycle from position 0 and marks it. Push read transactions (mode 1) to pop the child
// in order: a marked position gives the first parent's city, any other the second's, and
// the final city carries last. Loads beyond the tour and reads before it is full are
// dropped silently. The front end takes one transaction per cycle while its four-entry
// command queue has room. The back end writes a load as it pops it and, when the result queue
// has room, executes a read through a registered read of the parent and mark memories; the walk
// after the final load has a start state, then for each step a second-parent store read and a
// city map read, for at most tour_length steps. Results wait in a two-entry queue so the back
// end keeps going while the consumer stalls, until that queue fills. Writing tour_length
// (clamped to 2..MAX_CITIES) aborts any crossover; write it only when the block is idle.
// No clearing pass is needed after reset.

module permutation_cycle_crossover import pcx_pkg::*; #(
	parameter int MAX_CITIES = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// item side
	input  logic                  push,
	output logic                  full,
	input  item_t                 item,
	// result side
	output logic                  empty,
	input  logic                  pop,
	output result_t               result,
	// register port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int CNT_W = $clog2(MAX_CITIES + 1);
	localparam int CMD_W = $bits(cmd_t);
	localparam int RES_W = $bits(result_t);

	logic [TL_W-1:0]  tour_length_q;
	logic [CNT_W-1:0] n;
	logic             reg_hit, cfg_wr;

	logic       cmd_push, cmd_full, cmd_empty, cmd_pop;
	cmd_t       cmd_in, cmd_out;
	logic       out_push, out_full;
	result_t    out_data;

	// Register port: always ready, one register at word 0.
	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_TOUR_LENGTH);
	assign cfg_wr  = psel && penable && pwrite && reg_hit;
	assign prdata  = reg_hit ? APB_DATA_W'(tour_length_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tour_length_q <= TOUR_LENGTH_RESET;
		end else if (cfg_wr) begin
			tour_length_q <= pwdata[TL_W-1:0];
		end
	end

	// Clamp the programmed length to the range the stores support.
	always_comb begin
		if (32'(tour_length_q) < 32'd2) begin
			n = CNT_W'(2);
		end else if (32'(tour_length_q) > 32'(MAX_CITIES)) begin
			n = CNT_W'(MAX_CITIES);
		end else begin
			n = CNT_W'(tour_length_q);
		end
	end

	// Front end: classify each transaction, drop those that do nothing.
	pcx_front #(.MAX_CITIES(MAX_CITIES)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.n        (n),
		.cfg_wr   (cfg_wr),
		.push     (push),
		.item     (item),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	assign full = cmd_full;

	// Command queue decouples intake from execution.
	pcx_fifo #(.WIDTH(CMD_W), .DEPTH(4)) u_cmd_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out),
		.empty   (cmd_empty)
	);

	// Back end: stores, cycle walk and child reads.
	pcx_back #(.MAX_CITIES(MAX_CITIES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.n         (n),
		.cmd_valid (!cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_data  (out_data)
	);

	// Result queue: hold finished child cities until popped.
	pcx_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_result_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (out_data),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty)
	);

endmodule

// ===== src/pcx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module pcx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/pcx_fifo.sv =====
// Small first-in first-out queue in flip-flops, head shown combinationally.
// No dependencies.

module pcx_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/pcx_front.sv =====
// Front end: accepts items, tracks load and read counts, turns items into commands.
// Depends on pcx_pkg.

module pcx_front import pcx_pkg::*; #(
	parameter int MAX_CITIES = 128
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [$clog2(MAX_CITIES+1)-1:0]  n,
	input  logic                             cfg_wr,
	input  logic                             push,
	input  item_t                            item,
	input  logic                             cmd_full,
	output logic                             cmd_push,
	output cmd_t                             cmd
);

	localparam int CNT_W = $clog2(MAX_CITIES + 1);
	localparam int POS_W = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;

	logic [CNT_W-1:0] load_cnt_q;
	logic [POS_W-1:0] read_cnt_q;
	logic             is_load, load_ok, read_ok;

	assign is_load = (item.mode == MODE_LOAD);
	assign load_ok = (load_cnt_q < n);
	assign read_ok = (load_cnt_q == n);

	always_comb begin
		cmd.kind = is_load ? CMD_LOAD : CMD_READ;
		cmd.pos  = is_load ? CMD_POS_W'(load_cnt_q) : CMD_POS_W'(read_cnt_q);
		cmd.fc   = item.first_parent_city;
		cmd.sc   = item.second_parent_city;
		cmd.last = is_load ? ((load_cnt_q + CNT_W'(1)) == n)
		                   : ((CNT_W'(read_cnt_q) + CNT_W'(1)) == n);
		cmd_push = push && !cmd_full && (is_load ? load_ok : read_ok);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			read_cnt_q <= '0;
		end else if (cfg_wr) begin
			load_cnt_q <= '0;
			read_cnt_q <= '0;
		end else if (cmd_push) begin
			if (cmd.kind == CMD_LOAD) begin
				load_cnt_q <= load_cnt_q + CNT_W'(1);
			end else if (cmd.last) begin
				load_cnt_q <= '0;
				read_cnt_q <= '0;
			end else begin
				read_cnt_q <= read_cnt_q + POS_W'(1);
			end
		end
	end

endmodule

// ===== src/pcx_back.sv =====
// Back end: parent stores, city map and marks; executes loads, the cycle walk and child reads.
// Depends on pcx_pkg and pcx_ram.

module pcx_back import pcx_pkg::*; #(
	parameter int MAX_CITIES = 128
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [$clog2(MAX_CITIES+1)-1:0]  n,
	input  logic                             cmd_valid,
	input  cmd_t                             cmd,
	output logic                             cmd_pop,
	input  logic                             out_full,
	output logic                             out_push,
	output result_t                          out_data
);

	localparam int CNT_W = $clog2(MAX_CITIES + 1);
	localparam int POS_W = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;

	back_state_t state_q, state_d;

	logic [CITY_SLOTS-1:0] present_q;
	logic [CITY_W-1:0]     home_q;
	logic [CNT_W-1:0]      steps_q;
	logic [POS_W-1:0]      pos_q;
	logic                  fin_q;

	logic [POS_W-1:0]  cmd_pos;
	logic              do_load, do_read;
	logic              walk_stop, map_ok, walk_done;

	logic [CITY_W-1:0] fp_rdata, sp_rdata;
	logic [POS_W-1:0]  sp_raddr, map_rdata;
	logic              mark_we, mark_wdata, mark_rdata;
	logic [POS_W-1:0]  mark_waddr;

	assign cmd_pos = cmd.pos[POS_W-1:0];
	assign do_load = (state_q == BK_IDLE) && cmd_valid && (cmd.kind == CMD_LOAD);
	assign do_read = (state_q == BK_IDLE) && cmd_valid && (cmd.kind == CMD_READ) && !out_full;

	assign walk_stop = (sp_rdata == home_q) || !present_q[sp_rdata];
	assign map_ok    = (CNT_W'(map_rdata) < n);
	assign walk_done = ((steps_q + CNT_W'(1)) == n);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (do_load && cmd.last) begin
					state_d = BK_WALK_START;
				end else if (do_read) begin
					state_d = BK_READ;
				end
			end
			BK_READ:       state_d = BK_IDLE;
			BK_WALK_START: state_d = BK_WALK_SP;
			BK_WALK_SP:    state_d = walk_stop ? BK_IDLE : BK_WALK_MAP;
			BK_WALK_MAP:   state_d = (!map_ok || walk_done) ? BK_IDLE : BK_WALK_SP;
			default:       state_d = BK_IDLE;
		endcase
	end

	// outputs and memory controls
	always_comb begin
		cmd_pop    = do_load || do_read;
		out_push   = 1'b0;
		sp_raddr   = cmd_pos;
		mark_we    = do_load;
		mark_waddr = cmd_pos;
		mark_wdata = 1'b0;
		unique case (state_q)
			BK_IDLE: ;
			BK_READ: out_push = 1'b1;
			BK_WALK_START: begin
				sp_raddr   = '0;
				mark_we    = 1'b1;
				mark_waddr = '0;
				mark_wdata = 1'b1;
			end
			BK_WALK_SP: ;
			BK_WALK_MAP: begin
				sp_raddr   = map_rdata;
				mark_we    = map_ok;
				mark_waddr = map_rdata;
				mark_wdata = 1'b1;
			end
			default: ;
		endcase
		out_data.child_city     = mark_rdata ? fp_rdata : sp_rdata;
		out_data.child_position = OUT_POS_W'(pos_q);
		out_data.last           = fin_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			present_q <= '0;
		end else begin
			state_q <= state_d;
			if (do_load) begin
				present_q <= ((cmd_pos == '0) ? '0 : present_q)
				             | (CITY_SLOTS'(1) << cmd.fc);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_load && (cmd_pos == '0)) begin
			home_q <= cmd.fc;
		end
		if (do_read) begin
			pos_q <= cmd_pos;
			fin_q <= cmd.last;
		end
		if (state_q == BK_WALK_START) begin
			steps_q <= '0;
		end else if ((state_q == BK_WALK_MAP) && map_ok) begin
			steps_q <= steps_q + CNT_W'(1);
		end
	end

	pcx_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_first_store (
		.clk   (clk),
		.we    (do_load),
		.waddr (cmd_pos),
		.wdata (cmd.fc),
		.raddr (cmd_pos),
		.rdata (fp_rdata)
	);

	pcx_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_second_store (
		.clk   (clk),
		.we    (do_load),
		.waddr (cmd_pos),
		.wdata (cmd.sc),
		.raddr (sp_raddr),
		.rdata (sp_rdata)
	);

	pcx_ram #(.WIDTH(POS_W), .DEPTH(CITY_SLOTS)) u_city_map (
		.clk   (clk),
		.we    (do_load),
		.waddr (cmd.fc),
		.wdata (cmd_pos),
		.raddr (sp_rdata),
		.rdata (map_rdata)
	);

	pcx_ram #(.WIDTH(1), .DEPTH(MAX_CITIES)) u_marks (
		.clk   (clk),
		.we    (mark_we),
		.waddr (mark_waddr),
		.wdata (mark_wdata),
		.raddr (cmd_pos),
		.rdata (mark_rdata)
	);

endmodule

// ===== test/permutation_cycle_crossover_tb.sv =====
// Testbench for permutation_cycle_crossover: drives load and read transactions and APB writes,
// predicts every child city in a scoreboard class and checks the result queue against it.
// Depends on pcx_pkg and the permutation_cycle_crossover RTL under src.

module permutation_cycle_crossover_tb import pcx_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          MAXC      = 128;
	localparam int          ITEMS     = 1900;
	// worst back-end latency: a full walk plus the queues, with margin
	localparam int          QUIESCE   = 5 * MAXC + 64;
	localparam int          LIMIT     = 600000;
	localparam int          HOLD_LEN  = 400;
	localparam logic [APB_ADDR_W-1:0] TL_ADDR = APB_ADDR_W'(4 * REG_TOUR_LENGTH);

	// Expected child tour, built from the loaded parents and the cycle walk.
	class cx_scoreboard;
		bit [TL_W-1:0]   tour_len_reg;
		bit [CITY_W-1:0] first_tour  [MAXC];
		bit [CITY_W-1:0] second_tour [MAXC];
		int unsigned     city_slot   [CITY_SLOTS];
		bit              city_seen   [CITY_SLOTS];
		bit              in_cycle    [MAXC];
		int unsigned     loads_in;
		int unsigned     reads_out;
		result_t         child_q[$];
		int              errors;

		function new();
			tour_len_reg = TOUR_LENGTH_RESET;
			errors = 0;
			restart();
		endfunction

		function void restart();
			loads_in = 0;
			reads_out = 0;
			foreach (city_seen[i]) city_seen[i] = 1'b0;
			foreach (in_cycle[i]) in_cycle[i] = 1'b0;
		endfunction

		function int unsigned cities();
			if (tour_len_reg < 2) return 2;
			if (tour_len_reg > MAXC) return MAXC;
			return tour_len_reg;
		endfunction

		function void set_tour_length(bit [TL_W-1:0] v);
			tour_len_reg = v;
			restart();
		endfunction

		function int pending();
			return child_q.size();
		endfunction

		task report(string msg);
			$display("ERROR @%0t: %s", $time, msg);
			errors++;
		endtask

		// Follow the cycle from position 0; stop on home, an unknown city, a position past n, or after n steps.
		function void mark_cycle(int unsigned n);
			int unsigned     at;
			int unsigned     step;
			bit [CITY_W-1:0] home;
			bit [CITY_W-1:0] c;
			at = 0;
			home = first_tour[0];
			in_cycle[0] = 1'b1;
			for (step = 0; step < n; step++) begin
				c = second_tour[at];
				if (c == home || !city_seen[c]) break;
				at = city_slot[c];
				if (at >= n) break;
				in_cycle[at] = 1'b1;
			end
		endfunction

		// Returns 1 when the transaction takes effect, 0 when the block drops it.
		function bit note_item(item_t it);
			int unsigned n;
			result_t     r;
			n = cities();
			if (it.mode == MODE_LOAD) begin
				if (loads_in >= n) return 1'b0;
				first_tour[loads_in] = it.first_parent_city;
				second_tour[loads_in] = it.second_parent_city;
				city_slot[it.first_parent_city] = loads_in;
				city_seen[it.first_parent_city] = 1'b1;
				loads_in++;
				if (loads_in == n) mark_cycle(n);
				return 1'b1;
			end
			if (loads_in < n || reads_out >= n) return 1'b0;
			r.child_city = in_cycle[reads_out] ? first_tour[reads_out] : second_tour[reads_out];
			r.child_position = OUT_POS_W'(reads_out);
			r.last = (reads_out + 1 == n);
			child_q.push_back(r);
			if (r.last) restart();
			else reads_out++;
			return 1'b1;
		endfunction

		task check_result(result_t got);
			result_t want;
			if (child_q.size() == 0) begin
				report($sformatf("result with nothing expected: city %0d pos %0d last %0b",
					got.child_city, got.child_position, got.last));
				return;
			end
			want = child_q.pop_front();
			if (got.child_city != want.child_city)
				report($sformatf("child_city at pos %0d: got %0d, want %0d",
					want.child_position, got.child_city, want.child_city));
			if (got.child_position != want.child_position)
				report($sformatf("child_position: got %0d, want %0d",
					got.child_position, want.child_position));
			if (got.last != want.last)
				report($sformatf("last at pos %0d: got %0b, want %0b",
					want.child_position, got.last, want.last));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	item_t                 item;
	logic                  empty;
	logic                  pop;
	result_t               result;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	cx_scoreboard sb;
	int           hold_req = 0;     // receiver hold-off request, in cycles
	bit           quiet = 1'b0;     // no idling on either side once set
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;
	int           effective = 0;    // transactions that took effect
	int           cycles = 0;

	permutation_cycle_crossover u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: abandon the run if it hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("ERROR: timeout after %0d cycles, %0d results outstanding",
				cycles, sb.pending());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Check every popped transaction against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_result(result);
	end

	// Receiver: pops with random idle bursts, idle rate changed per window, plus a long hold-off on request.
	initial begin
		int burst;
		int window;
		burst = 0;
		window = 0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				pop = 1'b0;
				repeat (hold_req) @(negedge clk);
				hold_req = 0;
			end
			if (window == 0) begin
				case ($urandom_range(0, 2))
					0: recv_idle_pct = 0;
					1: recv_idle_pct = 12;
					default: recv_idle_pct = 35;
				endcase
				window = 128;
			end
			window--;
			if (burst > 0) begin
				pop = 1'b0;
				burst--;
			end else if (!quiet && recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) begin
				pop = 1'b0;
				burst = $urandom_range(0, 9);
			end else begin
				pop = 1'b1;
			end
		end
	end

	function automatic item_t mk_item(logic mode, int fc, int sc);
		item_t it;
		it.mode = mode;
		it.first_parent_city = CITY_W'(fc);
		it.second_parent_city = CITY_W'(sc);
		return it;
	endfunction

	// Offer one transaction and hold it until accepted; returns at a falling edge, push still high.
	task automatic push_item(item_t it);
		if (!quiet && send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			push = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		push = 1'b1;
		item = it;
		do @(posedge clk); while (full);
		if (sb.note_item(it)) effective++;
		@(negedge clk);
	endtask

	task automatic push_read();
		push_item(mk_item(MODE_READ, $urandom_range(0, 127), $urandom_range(0, 127)));
	endtask

	// Stop sending, wait for every expected result, then let the back end settle.
	task automatic drain();
		push = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (QUIESCE) @(negedge clk);
	endtask

	// Write tour_length, then read it back.
	task automatic write_tour_length(logic [APB_DATA_W-1:0] v);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = TL_ADDR;
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_tour_length(v[TL_W-1:0]);
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[TL_W-1:0] != v[TL_W-1:0])
			sb.report($sformatf("tour_length readback: got %0d, want %0d",
				prdata[TL_W-1:0], v[TL_W-1:0]));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// One crossover: mostly true permutations of a random city set, sometimes noise
	// with dropped transactions mixed in and the read-out cut short. A hold-off
	// crossover is always clean so the full read-out backs up against the receiver.
	task automatic run_crossover(int unsigned n, bit hold);
		int          pool [CITY_SLOTS];
		int          fp   [MAXC];
		int          sp   [MAXC];
		int          j;
		int          tmp;
		bit          clean;
		int unsigned rd_stop;
		clean = hold || ($urandom_range(0, 4) != 0);
		case ($urandom_range(0, 2))
			0: send_idle_pct = 0;
			1: send_idle_pct = 10;
			default: send_idle_pct = 30;
		endcase
		foreach (pool[i]) pool[i] = i;
		for (int i = CITY_SLOTS - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = pool[i];
			pool[i] = pool[j];
			pool[j] = tmp;
		end
		for (int i = 0; i < n; i++) begin
			fp[i] = pool[i];
			sp[i] = pool[i];
		end
		for (int i = n - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = sp[i];
			sp[i] = sp[j];
			sp[j] = tmp;
		end
		if (!clean) begin
			// duplicates and cities missing from the first parent
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 2) == 0) fp[i] = $urandom_range(0, 127);
				if ($urandom_range(0, 2) == 0) sp[i] = $urandom_range(0, 127);
			end
		end
		for (int i = 0; i < n; i++) begin
			if (!clean && $urandom_range(0, 5) == 0) push_read();
			push_item(mk_item(MODE_LOAD, fp[i], sp[i]));
		end
		if (!clean && $urandom_range(0, 1) == 0)
			push_item(mk_item(MODE_LOAD, $urandom_range(0, 127), $urandom_range(0, 127)));
		if (hold) hold_req = HOLD_LEN;
		rd_stop = n;
		if (!clean && $urandom_range(0, 3) == 0) rd_stop = $urandom_range(0, n - 1);
		for (int i = 0; i < rd_stop; i++) push_read();
	endtask

	initial begin
		logic [APB_DATA_W-1:0] fixed_len [7];
		logic [APB_DATA_W-1:0] tl_val;
		int                    ph;
		int                    xovers;
		int unsigned           n;
		fixed_len = '{32'd128, 32'd1, 32'd255, 32'hFFFF_FF06, 32'd100, 32'd129, 32'd2};
		sb = new();
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Tour length zero acts as two: read before full (dropped), swap cycle covering
		// both positions, load while full (dropped), read-out, read after the end (dropped).
		write_tour_length(32'd0);
		push_item(mk_item(MODE_READ, 127, 127));
		push_item(mk_item(MODE_LOAD, 0, 127));
		push_item(mk_item(MODE_LOAD, 127, 0));
		push_item(mk_item(MODE_LOAD, 64, 64));
		push_read();
		push_read();
		push_item(mk_item(MODE_READ, 0, 0));
		drain();

		// Three cities: duplicate in the first parent, a city missing from it,
		// and a walk that never returns home.
		write_tour_length(32'd3);
		push_item(mk_item(MODE_LOAD, 5, 9));
		push_item(mk_item(MODE_LOAD, 5, 100));
		push_item(mk_item(MODE_LOAD, 9, 5));
		repeat (3) push_read();
		push_item(mk_item(MODE_LOAD, 10, 20));
		push_item(mk_item(MODE_LOAD, 20, 77));
		push_item(mk_item(MODE_LOAD, 30, 10));
		repeat (3) push_read();
		push_item(mk_item(MODE_LOAD, 0, 1));
		push_item(mk_item(MODE_LOAD, 1, 2));
		push_item(mk_item(MODE_LOAD, 2, 1));
		repeat (3) push_read();
		drain();

		// Random phases: extremes first, then mostly short tours.
		ph = 0;
		while (effective < ITEMS) begin
			if (ph < 7) begin
				tl_val = fixed_len[ph];
			end else if ($urandom_range(0, 7) == 0) begin
				tl_val = $urandom_range(11, 64);
			end else begin
				tl_val = $urandom_range(0, 10);
			end
			quiet = (effective >= ITEMS - 250);
			write_tour_length(tl_val);
			n = sb.cities();
			xovers = (n > 32) ? 1 : $urandom_range(1, 4);
			for (int x = 0; x < xovers; x++)
				run_crossover(n, ph == 0 && x == 0);   // long receiver hold-off on the first full tour
			drain();
			ph++;
		end

		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		if (sb.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
